@@ design/olist_pkg.sv @@
// ----------------------------------------------------------------------------
// olist_pkg: shared types and codes for the ordered list
// Operation kinds, status codes, field widths and the command word that
// the list control broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package olist_pkg;

    // field widths
    localparam int KIND_W   = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 4;
    localparam int COUNT_W  = 5;

    // default list depth
    localparam int CAPACITY_DEF = 16;

    // operation kinds
    localparam logic [KIND_W-1:0] K_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] K_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] K_FIND   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // command broadcast to all cells
    typedef struct packed {
        logic                       ins;    // legal insert this cycle
        logic                       del;    // legal delete this cycle
        logic [POS_W-1:0]           pos;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

endpackage

@@ design/olist_cell.sv @@
// ----------------------------------------------------------------------------
// olist_cell: one slot of the ordered list
// Holds one entry. On insert it takes the new value or its lower
// neighbor's entry, on delete its upper neighbor's entry, and it always
// reports whether its occupied entry equals the broadcast value.
// ----------------------------------------------------------------------------
module olist_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                                i_clk,
    input  olist_pkg::t_cmd                     i_cmd,
    input  logic [CW-1:0]                       i_count,
    input  logic [olist_pkg::VALUE_W-1:0]       i_left,
    input  logic [olist_pkg::VALUE_W-1:0]       i_right,
    output logic [olist_pkg::VALUE_W-1:0]       o_entry,
    output logic                                o_match
);

    localparam int PW = (CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W;
    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [olist_pkg::VALUE_W-1:0] r_entry;
    logic [olist_pkg::VALUE_W-1:0] n_entry;
    logic [PW-1:0]                 pos_ext;
    logic [PW-1:0]                 count_ext;

    assign pos_ext   = PW'(i_cmd.pos);
    assign count_ext = PW'(i_count);

    // next entry: load, shift up from the left, shift down from the right
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (MY_IDX == pos_ext) begin
                n_entry = i_cmd.value;
            end else if (MY_IDX > pos_ext) begin
                n_entry = i_left;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= pos_ext) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // compare only while this slot is occupied
    assign o_match = (r_entry == i_cmd.value) && (MY_IDX < count_ext);
    assign o_entry = r_entry;

endmodule

@@ design/ordered_list_insert_delete_find.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_find: ordered list with insert, delete, find
// Chain of cells holding up to CAPACITY signed words plus a count.
// ----------------------------------------------------------------------------
// In the cycle a word is accepted, every cell shifts or loads in parallel
// and compares its entry with the value, and the match bits are captured;
// in the next cycle the lowest matching slot is picked and the result is
// loaded into the output register. One operation is in flight at a time:
// no word is taken while one is in flight or the output register holds an
// unread result. Positions are 0-based. Entries come up undefined and are
// only ever read below the count, which reset clears to zero.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_find #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [olist_pkg::KIND_W-1:0]        i_kind,
    input  logic [olist_pkg::POS_W-1:0]         i_position,
    input  logic signed [olist_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [olist_pkg::STATUS_W-1:0]      o_status,
    output logic [olist_pkg::FOUND_W-1:0]       o_found_position,
    output logic [olist_pkg::COUNT_W-1:0]       o_count
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = (CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W;
    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FXW = (IW > olist_pkg::FOUND_W) ? IW : olist_pkg::FOUND_W;
    localparam int CXW = (CW > olist_pkg::COUNT_W) ? CW : olist_pkg::COUNT_W;

    // control and count
    logic                               r_busy;
    logic                               r_is_find;
    logic [olist_pkg::STATUS_W-1:0]     r_status;
    logic [CAPACITY-1:0]                r_match;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      n_count;

    // output register
    logic                               r_out_valid;
    logic [olist_pkg::STATUS_W-1:0]     r_out_status;
    logic [olist_pkg::FOUND_W-1:0]      r_out_found;
    logic [olist_pkg::COUNT_W-1:0]      r_out_count;

    logic                               in_acc;
    logic                               is_full;
    logic [PW-1:0]                      pos_ext;
    logic [PW-1:0]                      count_ext;
    logic                               ins_ok;
    logic                               del_ok;
    logic [olist_pkg::STATUS_W-1:0]     n_status;
    olist_pkg::t_cmd                    cmd;

    logic [olist_pkg::VALUE_W-1:0]      cell_entry [CAPACITY];
    logic [CAPACITY-1:0]                cell_match;

    logic [FXW-1:0]                     found_idx;
    logic [olist_pkg::STATUS_W-1:0]     res_status;
    logic [olist_pkg::FOUND_W-1:0]      res_found;
    logic [CXW-1:0]                     count_wide;

    // handshake: one operation in flight, output register frees the input side
    assign o_in_ready = !r_busy && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    // legality checks, fullness first
    assign pos_ext   = PW'(i_position);
    assign count_ext = PW'(r_count);
    assign is_full   = (r_count == CW'(CAPACITY));
    assign ins_ok    = (i_kind == olist_pkg::K_INSERT) && !is_full && (pos_ext <= count_ext);
    assign del_ok    = (i_kind == olist_pkg::K_DELETE) && (pos_ext < count_ext);

    always_comb begin
        n_status = olist_pkg::ST_OK;
        unique case (i_kind)
            olist_pkg::K_INSERT: begin
                if (is_full) begin
                    n_status = olist_pkg::ST_FULL;
                end else if (!ins_ok) begin
                    n_status = olist_pkg::ST_ILLEGAL;
                end
            end
            olist_pkg::K_DELETE: begin
                if (!del_ok) begin
                    n_status = olist_pkg::ST_EMPTY;
                end
            end
            olist_pkg::K_FIND: n_status = olist_pkg::ST_NOT_FOUND;
            default:           n_status = olist_pkg::ST_ILLEGAL;
        endcase
    end

    // broadcast to the cells
    always_comb begin
        cmd.ins   = in_acc && ins_ok;
        cmd.del   = in_acc && del_ok;
        cmd.pos   = i_position;
        cmd.value = i_value;
    end

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [olist_pkg::VALUE_W-1:0] left_in;
        logic [olist_pkg::VALUE_W-1:0] right_in;

        if (g == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_left
            assign left_in = cell_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_right
            assign right_in = cell_entry[g+1];
        end

        olist_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_count (r_count),
            .i_left  (left_in),
            .i_right (right_in),
            .o_entry (cell_entry[g]),
            .o_match (cell_match[g])
        );
    end

    // count update
    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (cmd.del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= in_acc;
            r_count <= n_count;
        end
    end

    // capture status and match bits of the accepted word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status  <= n_status;
            r_is_find <= (i_kind == olist_pkg::K_FIND);
            r_match   <= cell_match;
        end
    end

    // lowest matching slot
    always_comb begin
        found_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                found_idx = FXW'(i);
            end
        end
    end

    always_comb begin
        res_status = r_status;
        res_found  = '0;
        if (r_is_find && (|r_match)) begin
            res_status = olist_pkg::ST_OK;
            res_found  = found_idx[olist_pkg::FOUND_W-1:0];
        end
    end

    assign count_wide = CXW'(r_count);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_out_status <= res_status;
            r_out_found  <= res_found;
            r_out_count  <= count_wide[olist_pkg::COUNT_W-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_found;
    assign o_count          = r_out_count;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count above capacity");

    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_out_valid)
        else $error("result pending while output register occupied");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_busy && !o_in_ready))
        else $error("accepted word not held for result stage");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.del |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the count");

endmodule
